// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define PDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Shared constants, codes and controller/datapath types of the polyline
// distance sampler.
// ----------------------------------------------------------------------------
package pds_pkg;

	localparam int MAX_POINTS = 256;
	localparam int FRAC_BITS  = 16;

	localparam int IDX_W   = $clog2(MAX_POINTS);
	localparam int CNT_W   = IDX_W + 1;
	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int LEN_W   = 33;
	localparam int RL_W    = 40;
	localparam int REL_W   = RL_W + 2;
	localparam int SQ_W    = 66;
	localparam int SPLIT   = 17;
	localparam int SQP_W   = DIFF_W + SPLIT;
	localparam int SREM_W  = LEN_W + 3;
	localparam int DIR_W   = 18;
	localparam int Q_W     = FRAC_BITS + 1;
	localparam int NUM_W   = LEN_W + Q_W;
	localparam int STEP_W  = 6;
	localparam int SQ_STEPS   = 6;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int POS_STEPS  = 3;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	localparam logic [1:0] RES_ZERO  = 2'd0;
	localparam logic [1:0] RES_FULL  = 2'd1;
	localparam logic [1:0] RES_SHORT = 2'd2;
	localparam logic [1:0] RES_QUERY = 2'd3;

	typedef struct packed {
		logic       load_in;
		logic       clr_count;
		logic       app_write;
		logic       sq_step;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       srch_init;
		logic       srch_rd;
		logic       srch_cmp;
		logic       rd_b;
		logic       cap_b;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic       pos_step;
		logic       step_clr;
		logic       res_load;
		logic [1:0] res_kind;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [CNT_W-1:0] count;
		logic             cnt_zero;
		logic             cnt_lt2;
		logic             cnt_full;
		logic             sq_last;
		logic             sqrt_last;
		logic             srch_stop;
		logic             div_last;
		logic             job_last;
		logic             pos_last;
	} stat_t;

endpackage

// ===== rtl/pds_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_in_if / pds_out_if
// Valid/ready channels of the sampler: command items in, results out.
// ----------------------------------------------------------------------------
interface pds_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           operation;
	logic signed [pds_pkg::COORD_W-1:0]   point_x;
	logic signed [pds_pkg::COORD_W-1:0]   point_y;
	logic signed [pds_pkg::COORD_W-1:0]   point_z;
	logic signed [pds_pkg::COORD_W-1:0]   query_distance;

	modport source (output valid, operation, point_x, point_y, point_z, query_distance,
		input ready);
	modport sink (input valid, operation, point_x, point_y, point_z, query_distance,
		output ready);
endinterface

interface pds_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [pds_pkg::COORD_W-1:0] pos_x;
	logic signed [pds_pkg::COORD_W-1:0] pos_y;
	logic signed [pds_pkg::COORD_W-1:0] pos_z;
	logic signed [pds_pkg::DIR_W-1:0]   dir_x;
	logic signed [pds_pkg::DIR_W-1:0]   dir_y;
	logic signed [pds_pkg::DIR_W-1:0]   dir_z;
	logic [1:0]                         status;

	modport source (output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, status,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, status,
		output ready);
endinterface

// ===== rtl/polyline_distance_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_distance_sampler
// Arc-length sampling of a stored 3-D Q16.16 polyline (top level).
// ----------------------------------------------------------------------------
// One transaction is in flight at a time; the input side is ready again as
// soon as the previous item's result sits in the output register, even if
// the sink has not taken it yet. Clear, dropped append, unused code and a
// query on fewer than two points go from dispatch straight to the result
// register. An append on an empty store is written at once; any other runs
// the split 33x17 squaring of the three axis differences, the bit-pair
// square root, then the write. A query searches for the segment that holds
// the distance, reading the running lengths one at a time from their RAM;
// then one restoring divider, FRAC_BITS+1 quotient bits wide (17 at
// Q16.16), is reused for the fraction and the three direction components,
// and one multiplier does the three interpolations. Segment lengths are
// kept in their own RAM at append time so a query never recomputes a
// root. All stores are plain RAMs; entries at or beyond the point count
// are never read, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module polyline_distance_sampler (
	input logic      clk,
	input logic      arst_n,
	pds_in_if.sink   in_ch,
	pds_out_if.source out_ch
);

`include "assert_macros.svh"

	pds_pkg::cmd_t  cmd;
	pds_pkg::stat_t stat;

	// sequencer: handshakes and step commands
	pds_ctrl u_ctrl (
		.clk,
		.arst_n,
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat,
		.cmd
	);

	// datapath: stores, length unit, divider, interpolator, result register
	pds_dp u_dp (
		.clk,
		.arst_n,
		.cmd,
		.stat,
		.in_operation (in_ch.operation),
		.in_x         (in_ch.point_x),
		.in_y         (in_ch.point_y),
		.in_z         (in_ch.point_z),
		.in_dist      (in_ch.query_distance),
		.pos_x        (out_ch.pos_x),
		.pos_y        (out_ch.pos_y),
		.pos_z        (out_ch.pos_z),
		.dir_x        (out_ch.dir_x),
		.dir_y        (out_ch.dir_y),
		.dir_z        (out_ch.dir_z),
		.status       (out_ch.status)
	);

	// a taken transaction blocks the input until its result is registered
	`PDS_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "input accepted while busy")
	// a result never overwrites one the sink has not taken
	`PDS_ASSERT_NOW(a_no_overwrite, cmd.res_load, !out_ch.valid || out_ch.ready, "result overwritten")
	// the point count stays within the store
	`PDS_ASSERT_NOW(a_count_range, 1'b1, stat.count <= pds_pkg::CNT_W'(pds_pkg::MAX_POINTS), "point count overflow")

endmodule

// ===== rtl/pds_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/pds_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_dp
// Datapath: point stores, segment length unit (split squares + bit-pair
// root), running-length search, shared restoring divider, interpolator.
// ----------------------------------------------------------------------------
module pds_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pds_pkg::cmd_t                       cmd,
	output pds_pkg::stat_t                      stat,
	input  logic [1:0]                          in_operation,
	input  logic signed [pds_pkg::COORD_W-1:0]  in_x,
	input  logic signed [pds_pkg::COORD_W-1:0]  in_y,
	input  logic signed [pds_pkg::COORD_W-1:0]  in_z,
	input  logic signed [pds_pkg::COORD_W-1:0]  in_dist,
	output logic signed [pds_pkg::COORD_W-1:0]  pos_x,
	output logic signed [pds_pkg::COORD_W-1:0]  pos_y,
	output logic signed [pds_pkg::COORD_W-1:0]  pos_z,
	output logic signed [pds_pkg::DIR_W-1:0]    dir_x,
	output logic signed [pds_pkg::DIR_W-1:0]    dir_y,
	output logic signed [pds_pkg::DIR_W-1:0]    dir_z,
	output logic [1:0]                          status
);

	// captured item
	logic [1:0]                          op_q;
	logic signed [pds_pkg::COORD_W-1:0]  px_q, py_q, pz_q, dist_q;

	// curve bookkeeping
	logic [pds_pkg::CNT_W-1:0]           count_q;
	logic signed [pds_pkg::COORD_W-1:0]  last_q [3];
	logic signed [pds_pkg::COORD_W-1:0]  first_q [3];
	logic [pds_pkg::RL_W-1:0]            rl_last_q;

	logic [pds_pkg::STEP_W-1:0]          step_q;

	// segment length unit
	logic [pds_pkg::SQP_W-1:0]           sqp_q;
	logic [pds_pkg::SQ_W-1:0]            acc_q;
	logic [pds_pkg::SQ_W-1:0]            rad_q;
	logic [pds_pkg::SREM_W-1:0]          srem_q;
	logic [pds_pkg::LEN_W-1:0]           root_q;

	// query path
	logic [pds_pkg::IDX_W-1:0]           idx_q;
	logic signed [pds_pkg::COORD_W-1:0]  a_q [3];
	logic signed [pds_pkg::DIFF_W-1:0]   d_q [3];
	logic [pds_pkg::RL_W-1:0]            rl_sel_q;
	logic [pds_pkg::LEN_W-1:0]           len_q;
	logic signed [pds_pkg::REL_W-1:0]    rel_q;
	logic [1:0]                          job_q;
	logic [pds_pkg::LEN_W-1:0]           drem_q;
	logic [pds_pkg::Q_W-1:0]             nsh_q;
	logic [pds_pkg::Q_W-1:0]             quo_q;
	logic [pds_pkg::Q_W-1:0]             t_q;
	logic signed [pds_pkg::DIR_W-1:0]    dir_q [3];
	logic signed [pds_pkg::DIFF_W+pds_pkg::Q_W:0] prod_s1;
	logic signed [pds_pkg::COORD_W-1:0]  pos_q [3];

	// result register
	logic signed [pds_pkg::COORD_W-1:0]  res_pos_q [3];
	logic signed [pds_pkg::DIR_W-1:0]    res_dir_q [3];
	logic [1:0]                          res_status_q;

	// RAM ports
	logic                                pt_we, len_we;
	logic [pds_pkg::IDX_W-1:0]           wr_addr, len_waddr, pt_raddr, rl_raddr;
	logic [pds_pkg::COORD_W-1:0]         rx, ry, rz;
	logic [pds_pkg::RL_W-1:0]            rl_rdata, rl_new;
	logic [pds_pkg::LEN_W-1:0]           len_rdata;

	// ---------------- combinational helpers ----------------
	logic signed [pds_pkg::DIFF_W-1:0]   app_d;
	logic [pds_pkg::DIFF_W-1:0]          app_m;
	logic [pds_pkg::SPLIT-1:0]           sq_op;
	logic [pds_pkg::SQ_W-1:0]            sq_add;
	logic [pds_pkg::SREM_W-1:0]          s_two, s_trial;
	logic [pds_pkg::RL_W:0]              rl_sum;
	logic                                hit, last_seg;
	logic [1:0]                          comp_sel;
	logic signed [pds_pkg::DIFF_W-1:0]   d_cur;
	logic [pds_pkg::DIFF_W-1:0]          d_mag;
	logic signed [pds_pkg::COORD_W-1:0]  a_cur;
	logic [1:0]                          pidx;
	logic [pds_pkg::NUM_W-1:0]           num;
	logic [pds_pkg::LEN_W:0]             r2;
	logic                                q_ge;
	logic signed [pds_pkg::Q_W:0]        q_signed;
	logic signed [pds_pkg::DIFF_W+pds_pkg::Q_W:0] prod_sh;
	logic [pds_pkg::Q_W-1:0]             t_val;
	logic signed [pds_pkg::DIR_W-1:0]    dir_up;

	assign dir_up = pds_pkg::DIR_W'(pds_pkg::Q_W'(1) << pds_pkg::FRAC_BITS);

	// appended segment difference, one axis per two squaring steps
	always_comb begin
		case (step_q[2:1])
			2'd0:    app_d = pds_pkg::DIFF_W'(px_q) - pds_pkg::DIFF_W'(last_q[0]);
			2'd1:    app_d = pds_pkg::DIFF_W'(py_q) - pds_pkg::DIFF_W'(last_q[1]);
			default: app_d = pds_pkg::DIFF_W'(pz_q) - pds_pkg::DIFF_W'(last_q[2]);
		endcase
		app_m = app_d[pds_pkg::DIFF_W-1] ? pds_pkg::DIFF_W'(-app_d) : app_d;
		sq_op = step_q[0] ? pds_pkg::SPLIT'(app_m[pds_pkg::DIFF_W-1:pds_pkg::SPLIT])
		                  : app_m[pds_pkg::SPLIT-1:0];
		// previous step's product: low half on odd steps, shifted high half on even
		sq_add = step_q[0] ? pds_pkg::SQ_W'(sqp_q)
		                   : pds_pkg::SQ_W'({sqp_q, {pds_pkg::SPLIT{1'b0}}});
	end

	assign s_two   = {srem_q[pds_pkg::SREM_W-3:0], rad_q[pds_pkg::SQ_W-1 -: 2]};
	assign s_trial = pds_pkg::SREM_W'({root_q, 2'b01});

	assign rl_sum = {1'b0, rl_last_q} + (pds_pkg::RL_W+1)'(root_q);
	assign rl_new = (count_q == '0) ? '0
	              : (rl_sum[pds_pkg::RL_W] ? {pds_pkg::RL_W{1'b1}} : rl_sum[pds_pkg::RL_W-1:0]);

	assign hit = $signed({{(pds_pkg::RL_W-pds_pkg::COORD_W+1){dist_q[pds_pkg::COORD_W-1]}},
	                      dist_q}) <= $signed({1'b0, rl_rdata});
	assign last_seg = ({1'b0, idx_q} == (count_q - pds_pkg::CNT_W'(2)));

	assign comp_sel = cmd.pos_step ? step_q[1:0] : (job_q - 2'd1);
	always_comb begin
		case (comp_sel)
			2'd0:    d_cur = d_q[0];
			2'd1:    d_cur = d_q[1];
			default: d_cur = d_q[2];
		endcase
		d_mag = d_cur[pds_pkg::DIFF_W-1] ? pds_pkg::DIFF_W'(-d_cur) : d_cur;
		pidx = step_q[1:0] - 2'd1;
		case (pidx)
			2'd0:    a_cur = a_q[0];
			2'd1:    a_cur = a_q[1];
			default: a_cur = a_q[2];
		endcase
	end

	// divider numerator: fraction job first, then rounded unit components
	always_comb begin
		if (job_q == 2'd0) begin
			num = pds_pkg::NUM_W'({rel_q[pds_pkg::LEN_W-1:0], {pds_pkg::FRAC_BITS{1'b0}}});
		end else begin
			num = pds_pkg::NUM_W'({d_mag, {pds_pkg::FRAC_BITS{1'b0}}})
			    + pds_pkg::NUM_W'(len_q >> 1);
		end
	end

	assign r2   = {drem_q, nsh_q[pds_pkg::Q_W-1]};
	assign q_ge = r2 >= {1'b0, len_q};
	assign q_signed = d_cur[pds_pkg::DIFF_W-1] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_comb begin
		if (len_q == '0 || rel_q <= 0) begin
			t_val = '0;
		end else if (rel_q >= $signed(pds_pkg::REL_W'(len_q))) begin
			t_val = pds_pkg::Q_W'(1) << pds_pkg::FRAC_BITS;
		end else begin
			t_val = quo_q;
		end
	end

	assign prod_sh = prod_s1 >>> pds_pkg::FRAC_BITS;

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			step_q  <= '0;
		end else begin
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.app_write) begin
				count_q <= count_q + pds_pkg::CNT_W'(1);
			end
			if (cmd.step_clr || cmd.sqrt_init || cmd.div_load) begin
				step_q <= '0;
			end else if (cmd.sq_step || cmd.sqrt_step || cmd.div_step || cmd.pos_step) begin
				step_q <= step_q + pds_pkg::STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= in_operation;
			px_q   <= in_x;
			py_q   <= in_y;
			pz_q   <= in_z;
			dist_q <= in_dist;
		end
		if (cmd.app_write) begin
			last_q[0] <= px_q;
			last_q[1] <= py_q;
			last_q[2] <= pz_q;
			rl_last_q <= rl_new;
			if (count_q == '0) begin
				first_q[0] <= px_q;
				first_q[1] <= py_q;
				first_q[2] <= pz_q;
			end
		end

		if (cmd.step_clr) begin
			acc_q <= '0;
		end else if (cmd.sq_step) begin
			sqp_q <= pds_pkg::SQP_W'(app_m * sq_op);
			if (step_q != '0) begin
				acc_q <= acc_q + sq_add;
			end
		end

		if (cmd.sqrt_init) begin
			rad_q  <= acc_q;
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[pds_pkg::SQ_W-3:0], 2'b00};
			if (s_two >= s_trial) begin
				srem_q <= s_two - s_trial;
				root_q <= {root_q[pds_pkg::LEN_W-2:0], 1'b1};
			end else begin
				srem_q <= s_two;
				root_q <= {root_q[pds_pkg::LEN_W-2:0], 1'b0};
			end
		end

		if (cmd.srch_init) begin
			idx_q <= '0;
		end else if (cmd.srch_cmp && !(hit || last_seg)) begin
			idx_q <= idx_q + pds_pkg::IDX_W'(1);
		end

		if (cmd.rd_b) begin
			a_q[0]   <= $signed(rx);
			a_q[1]   <= $signed(ry);
			a_q[2]   <= $signed(rz);
			rl_sel_q <= rl_rdata;
			len_q    <= len_rdata;
		end
		if (cmd.cap_b) begin
			d_q[0] <= pds_pkg::DIFF_W'($signed(rx)) - pds_pkg::DIFF_W'(a_q[0]);
			d_q[1] <= pds_pkg::DIFF_W'($signed(ry)) - pds_pkg::DIFF_W'(a_q[1]);
			d_q[2] <= pds_pkg::DIFF_W'($signed(rz)) - pds_pkg::DIFF_W'(a_q[2]);
			rel_q  <= pds_pkg::REL_W'(dist_q) - $signed({2'b00, rl_sel_q});
			job_q  <= 2'd0;
		end

		if (cmd.div_load) begin
			drem_q <= num[pds_pkg::NUM_W-1:pds_pkg::Q_W];
			nsh_q  <= num[pds_pkg::Q_W-1:0];
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			drem_q <= q_ge ? pds_pkg::LEN_W'(r2 - {1'b0, len_q}) : r2[pds_pkg::LEN_W-1:0];
			nsh_q  <= {nsh_q[pds_pkg::Q_W-2:0], 1'b0};
			quo_q  <= {quo_q[pds_pkg::Q_W-2:0], q_ge};
		end
		if (cmd.div_store) begin
			job_q <= job_q + 2'd1;
			case (job_q)
				2'd0: t_q <= t_val;
				2'd1: dir_q[0] <= (len_q == '0) ? '0 : pds_pkg::DIR_W'(q_signed);
				2'd2: dir_q[1] <= (len_q == '0) ? '0 : pds_pkg::DIR_W'(q_signed);
				default: dir_q[2] <= (len_q == '0) ? '0 : pds_pkg::DIR_W'(q_signed);
			endcase
		end

		if (cmd.pos_step) begin
			prod_s1 <= d_cur * $signed({1'b0, t_q});
			if (step_q != '0) begin
				case (pidx)
					2'd0:    pos_q[0] <= pds_pkg::COORD_W'(a_cur + prod_sh);
					2'd1:    pos_q[1] <= pds_pkg::COORD_W'(a_cur + prod_sh);
					default: pos_q[2] <= pds_pkg::COORD_W'(a_cur + prod_sh);
				endcase
			end
		end

		if (cmd.res_load) begin
			case (cmd.res_kind)
				pds_pkg::RES_QUERY: begin
					res_pos_q    <= pos_q;
					res_dir_q    <= dir_q;
					res_status_q <= pds_pkg::ST_DONE;
				end
				pds_pkg::RES_SHORT: begin
					if (count_q == '0) begin
						res_pos_q <= '{default: '0};
					end else begin
						res_pos_q <= first_q;
					end
					res_dir_q    <= '{'0, dir_up, '0};
					res_status_q <= pds_pkg::ST_SHORT;
				end
				pds_pkg::RES_FULL: begin
					res_pos_q    <= '{default: '0};
					res_dir_q    <= '{default: '0};
					res_status_q <= pds_pkg::ST_FULL;
				end
				default: begin
					res_pos_q    <= '{default: '0};
					res_dir_q    <= '{default: '0};
					res_status_q <= pds_pkg::ST_DONE;
				end
			endcase
		end
	end

	// ---------------- stores ----------------
	assign pt_we     = cmd.app_write;
	assign len_we    = cmd.app_write && (count_q != '0);
	assign wr_addr   = count_q[pds_pkg::IDX_W-1:0];
	assign len_waddr = wr_addr - pds_pkg::IDX_W'(1);
	assign pt_raddr  = cmd.rd_b ? idx_q + pds_pkg::IDX_W'(1) : idx_q;
	assign rl_raddr  = cmd.srch_rd ? idx_q + pds_pkg::IDX_W'(1) : idx_q;

	pds_ram #(.WIDTH(pds_pkg::COORD_W), .DEPTH(pds_pkg::MAX_POINTS)) u_ram_x (
		.clk, .we(pt_we), .waddr(wr_addr), .wdata(px_q), .raddr(pt_raddr), .rdata(rx));
	pds_ram #(.WIDTH(pds_pkg::COORD_W), .DEPTH(pds_pkg::MAX_POINTS)) u_ram_y (
		.clk, .we(pt_we), .waddr(wr_addr), .wdata(py_q), .raddr(pt_raddr), .rdata(ry));
	pds_ram #(.WIDTH(pds_pkg::COORD_W), .DEPTH(pds_pkg::MAX_POINTS)) u_ram_z (
		.clk, .we(pt_we), .waddr(wr_addr), .wdata(pz_q), .raddr(pt_raddr), .rdata(rz));
	pds_ram #(.WIDTH(pds_pkg::RL_W), .DEPTH(pds_pkg::MAX_POINTS)) u_ram_rl (
		.clk, .we(pt_we), .waddr(wr_addr), .wdata(rl_new), .raddr(rl_raddr),
		.rdata(rl_rdata));
	pds_ram #(.WIDTH(pds_pkg::LEN_W), .DEPTH(pds_pkg::MAX_POINTS)) u_ram_len (
		.clk, .we(len_we), .waddr(len_waddr), .wdata(root_q), .raddr(idx_q),
		.rdata(len_rdata));

	// ---------------- status and outputs ----------------
	always_comb begin
		stat.op        = op_q;
		stat.count     = count_q;
		stat.cnt_zero  = (count_q == '0);
		stat.cnt_lt2   = (count_q < pds_pkg::CNT_W'(2));
		stat.cnt_full  = (count_q == pds_pkg::CNT_W'(pds_pkg::MAX_POINTS));
		stat.sq_last   = (step_q == pds_pkg::STEP_W'(pds_pkg::SQ_STEPS));
		stat.sqrt_last = (step_q == pds_pkg::STEP_W'(pds_pkg::SQRT_STEPS - 1));
		stat.srch_stop = hit || last_seg;
		stat.div_last  = (step_q == pds_pkg::STEP_W'(pds_pkg::Q_W - 1));
		stat.job_last  = (job_q == 2'd3);
		stat.pos_last  = (step_q == pds_pkg::STEP_W'(pds_pkg::POS_STEPS));
	end

	assign pos_x  = res_pos_q[0];
	assign pos_y  = res_pos_q[1];
	assign pos_z  = res_pos_q[2];
	assign dir_x  = res_dir_q[0];
	assign dir_y  = res_dir_q[1];
	assign dir_z  = res_dir_q[2];
	assign status = res_status_q;

endmodule

// ===== rtl/pds_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer of the sampler: dispatches items, steps the datapath units and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module pds_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pds_pkg::stat_t stat,
	output pds_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_SQ   = 4'd2;
	localparam logic [3:0] S_SQI  = 4'd3;
	localparam logic [3:0] S_SQRT = 4'd4;
	localparam logic [3:0] S_WR   = 4'd5;
	localparam logic [3:0] S_SRD  = 4'd6;
	localparam logic [3:0] S_SCMP = 4'd7;
	localparam logic [3:0] S_RDA  = 4'd8;
	localparam logic [3:0] S_RDB  = 4'd9;
	localparam logic [3:0] S_CAPB = 4'd10;
	localparam logic [3:0] S_DLD  = 4'd11;
	localparam logic [3:0] S_DRUN = 4'd12;
	localparam logic [3:0] S_DST  = 4'd13;
	localparam logic [3:0] S_POS  = 4'd14;
	localparam logic [3:0] S_FIN  = 4'd15;

	logic [3:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		cmd.res_kind = kind_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				kind_d  = pds_pkg::RES_ZERO;
				case (stat.op)
					pds_pkg::OP_CLEAR: cmd.clr_count = 1'b1;
					pds_pkg::OP_APPEND: begin
						if (stat.cnt_full) begin
							kind_d = pds_pkg::RES_FULL;
						end else if (stat.cnt_zero) begin
							state_d = S_WR;
						end else begin
							cmd.step_clr = 1'b1;
							state_d = S_SQ;
						end
					end
					pds_pkg::OP_QUERY: begin
						if (stat.cnt_lt2) begin
							kind_d = pds_pkg::RES_SHORT;
						end else begin
							cmd.srch_init = 1'b1;
							kind_d  = pds_pkg::RES_QUERY;
							state_d = S_SRD;
						end
					end
					default: ;
				endcase
			end
			S_SQ: begin
				cmd.sq_step = 1'b1;
				if (stat.sq_last) begin
					state_d = S_SQI;
				end
			end
			S_SQI: begin
				cmd.sqrt_init = 1'b1;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (stat.sqrt_last) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				cmd.app_write = 1'b1;
				state_d = S_FIN;
			end
			S_SRD: begin
				cmd.srch_rd = 1'b1;
				state_d = S_SCMP;
			end
			S_SCMP: begin
				cmd.srch_cmp = 1'b1;
				state_d = stat.srch_stop ? S_RDA : S_SRD;
			end
			S_RDA: state_d = S_RDB;
			S_RDB: begin
				cmd.rd_b = 1'b1;
				state_d = S_CAPB;
			end
			S_CAPB: begin
				cmd.cap_b = 1'b1;
				state_d = S_DLD;
			end
			S_DLD: begin
				cmd.div_load = 1'b1;
				state_d = S_DRUN;
			end
			S_DRUN: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_DST;
				end
			end
			S_DST: begin
				cmd.div_store = 1'b1;
				if (stat.job_last) begin
					cmd.step_clr = 1'b1;
					state_d = S_POS;
				end else begin
					state_d = S_DLD;
				end
			end
			S_POS: begin
				cmd.pos_step = 1'b1;
				if (stat.pos_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= pds_pkg::RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== bench/pds_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_checker
// Watches both channels of the polyline distance sampler, predicts each result
// from a local copy of the point store and compares every field.
// ----------------------------------------------------------------------------
module pds_checker
	import pds_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	pds_in_if     in_ch,
	pds_out_if    out_ch,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		logic signed [31:0] px, py, pz;
		logic signed [17:0] dx, dy, dz;
		logic [1:0]         st;
	} sample_t;

	logic signed [31:0] pt_x [MAX_POINTS];
	logic signed [31:0] pt_y [MAX_POINTS];
	logic signed [31:0] pt_z [MAX_POINTS];
	logic [39:0]        arc_len [MAX_POINTS];
	int unsigned        npts;
	sample_t            sample_q[$];
	int                 mism;

	assign pending = sample_q.size();

	function automatic logic [32:0] isqrt(logic [65:0] v);
		logic [32:0] r;
		logic [32:0] c;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			c = r | (33'd1 << b);
			if ({66'd0, c} * {66'd0, c} <= {66'd0, v})
				r = c;
		end
		return r;
	endfunction

	function automatic logic [32:0] seg_length(int unsigned i);
		longint ddx, ddy, ddz;
		logic [65:0] s;
		ddx = longint'(pt_x[i+1]) - longint'(pt_x[i]);
		ddy = longint'(pt_y[i+1]) - longint'(pt_y[i]);
		ddz = longint'(pt_z[i+1]) - longint'(pt_z[i]);
		s = 66'(ddx * ddx) + 66'(ddy * ddy) + 66'(ddz * ddz);
		return isqrt(s);
	endfunction

	function automatic longint floor_q(longint v);
		if (v >= 0)
			return v >>> FRAC_BITS;
		return -((-v + (longint'(1) << FRAC_BITS) - 1) >>> FRAC_BITS);
	endfunction

	function automatic longint unit_part(longint d, longint len);
		longint q;
		q = (((d < 0 ? -d : d) << FRAC_BITS) + (len >>> 1)) / len;
		return d < 0 ? -q : q;
	endfunction

	function automatic sample_t sample_curve(logic signed [31:0] qd);
		sample_t r;
		int unsigned sel;
		longint len, rel, t, qdist;
		longint a[3], d[3];
		r = '0;
		qdist = longint'(qd);
		if (npts < 2) begin
			r.st = ST_SHORT;
			r.dy = 18'(1 << FRAC_BITS);
			if (npts == 1) begin
				r.px = pt_x[0]; r.py = pt_y[0]; r.pz = pt_z[0];
			end
			return r;
		end
		sel = npts - 2;
		for (int unsigned i = 0; i + 1 < npts; i++)
			if (qdist <= longint'({24'd0, arc_len[i+1]})) begin
				sel = i;
				break;
			end
		len = longint'(seg_length(sel));
		a[0] = pt_x[sel]; a[1] = pt_y[sel]; a[2] = pt_z[sel];
		d[0] = longint'(pt_x[sel+1]) - a[0];
		d[1] = longint'(pt_y[sel+1]) - a[1];
		d[2] = longint'(pt_z[sel+1]) - a[2];
		rel = qdist - longint'({24'd0, arc_len[sel]});
		if (len == 0 || rel <= 0)
			t = 0;
		else if (rel >= len)
			t = longint'(1) << FRAC_BITS;
		else
			t = (rel << FRAC_BITS) / len;
		r.px = 32'(a[0] + floor_q(d[0] * t));
		r.py = 32'(a[1] + floor_q(d[1] * t));
		r.pz = 32'(a[2] + floor_q(d[2] * t));
		if (len != 0) begin
			r.dx = 18'(unit_part(d[0], len));
			r.dy = 18'(unit_part(d[1], len));
			r.dz = 18'(unit_part(d[2], len));
		end
		r.st = ST_DONE;
		return r;
	endfunction

	// predict on every accepted input transaction
	always @(posedge clk) begin
		sample_t e;
		logic [40:0] s;
		if (!arst_n) begin
			npts = 0;
		end else if (in_ch.valid && in_ch.ready) begin
			e = '0;
			case (in_ch.operation)
				OP_CLEAR: npts = 0;
				OP_APPEND: begin
					if (npts >= MAX_POINTS) begin
						e.st = ST_FULL;
					end else begin
						pt_x[npts] = in_ch.point_x;
						pt_y[npts] = in_ch.point_y;
						pt_z[npts] = in_ch.point_z;
						if (npts == 0) begin
							arc_len[0] = '0;
						end else begin
							s = {1'b0, arc_len[npts-1]} + 41'(seg_length(npts - 1));
							arc_len[npts] = s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
						end
						npts++;
					end
				end
				OP_QUERY: e = sample_curve(in_ch.query_distance);
				default: ;
			endcase
			sample_q = {sample_q, e};
		end
	end

	// compare on every accepted output transaction
	always @(posedge clk or negedge arst_n) begin
		sample_t got, exp_s;
		if (!arst_n) begin
			fail_count <= 0;
			mism = 0;
		end else if (out_ch.valid && out_ch.ready) begin
			got = '{out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
				out_ch.dir_x, out_ch.dir_y, out_ch.dir_z, out_ch.status};
			if (sample_q.size() == 0) begin
				mism++;
				fail_count <= mism;
				if (mism <= 10)
					$display("%0t: result with nothing expected", $realtime);
			end else begin
				exp_s = sample_q.pop_front();
				if (got !== exp_s) begin
					mism++;
					fail_count <= mism;
					if (mism <= 10)
						$display("%0t: mismatch exp pos %0d %0d %0d dir %0d %0d %0d st %0d",
							$realtime, exp_s.px, exp_s.py, exp_s.pz, exp_s.dx, exp_s.dy,
							exp_s.dz, exp_s.st,
							" / got pos %0d %0d %0d dir %0d %0d %0d st %0d",
							got.px, got.py, got.pz, got.dx, got.dy, got.dz, got.st);
				end
			end
		end
	end

endmodule

// ===== bench/tb_polyline_distance_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_distance_sampler
// Drives clear, append, query and unused-code items with random gaps and
// output stalls; pds_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_polyline_distance_sampler;
	import pds_pkg::*;

	// operation code with no function
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles = 0;

	pds_in_if  in_ch();
	pds_out_if out_ch();

	polyline_distance_sampler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	pds_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: sized for the worst query plus long stalls, 1500+ items
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 3_000_000) begin
			$display("tb_polyline_distance_sampler: FAIL");
			$finish;
		end
	end

	// gap length: mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// sink side stalls at random; a stall-free window now and then
	always @(posedge clk) begin
		int w;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			w = $urandom_range(0, 99);
			if (cycles % 4000 < 800)
				out_ch.ready <= 1'b1;
			else if (w < 3)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
		end
	end

	// one transaction: hold valid until accepted, then gap
	task automatic send(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic signed [31:0] q);
		int g;
		in_ch.valid          <= 1'b1;
		in_ch.operation      <= op;
		in_ch.point_x        <= x;
		in_ch.point_y        <= y;
		in_ch.point_z        <= z;
		in_ch.query_distance <= q;
		do @(posedge clk); while (!in_ch.ready);
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rnd_coord(int scale);
		case (scale)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			default: return 32'($signed($urandom_range(0, 400)) - 200);
		endcase
	endfunction

	task automatic append_rnd(int scale);
		send(OP_APPEND, rnd_coord(scale), rnd_coord(scale), rnd_coord(scale), $urandom());
	endtask

	task automatic query_rnd();
		logic [31:0] q;
		case ($urandom_range(0, 5))
			0: q = $urandom();
			1: q = 32'h8000_0000;
			2: q = 32'h7FFF_FFFF;
			default: q = $urandom_range(0, 32'h0400_0000);
		endcase
		send(OP_QUERY, $urandom(), $urandom(), $urandom(), q);
	endtask

	initial begin
		int n;
		int sc;
		arst_n               = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.operation      = OP_CLEAR;
		in_ch.point_x        = '0;
		in_ch.point_y        = '0;
		in_ch.point_z        = '0;
		in_ch.query_distance = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty, single point, zero-length segment, extremes
		send(OP_QUERY, 0, 0, 0, 32'sd100);
		send(OP_UNUSED, -1, -1, -1, -1);
		send(OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send(OP_QUERY, 0, 0, 0, 0);
		send(OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send(OP_QUERY, 0, 0, 0, 32'sd5);
		send(OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send(OP_QUERY, 0, 0, 0, 32'h8000_0000);
		send(OP_QUERY, 0, 0, 0, 32'h7FFF_FFFF);
		send(OP_QUERY, 0, 0, 0, 32'h4000_0000);
		send(OP_APPEND, 0, 0, 0, 0);
		send(OP_QUERY, 0, 0, 0, 32'h7FFF_FFFF);
		send(OP_APPEND, -1, -1, -1, 0);
		send(OP_QUERY, 0, 0, 0, -1);
		send(OP_CLEAR, 0, 0, 0, 0);
		send(OP_QUERY, 0, 0, 0, 0);

		// fill the store to capacity and overflow it
		for (int i = 0; i < MAX_POINTS + 3; i++)
			append_rnd(i % 3);
		for (int i = 0; i < 6; i++)
			query_rnd();

		// hold off until every expected result is back
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);

		// random: short curves built up and sampled, with noise
		n = 0;
		while (n < 1220) begin
			send(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
			n++;
			sc = $urandom_range(0, 2);
			repeat ($urandom_range(0, 8)) begin
				if ($urandom_range(0, 9) == 0)
					send(OP_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());
				else if ($urandom_range(0, 2) == 0)
					query_rnd();
				else
					append_rnd(sc);
				n++;
			end
			repeat ($urandom_range(1, 6)) begin
				query_rnd();
				n++;
			end
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_polyline_distance_sampler: PASS");
		else
			$display("tb_polyline_distance_sampler: FAIL");
		$finish;
	end

endmodule

// ===== polyline_distance_sampler.f =====
+incdir+rtl
rtl/pds_pkg.sv
rtl/pds_if.sv
rtl/pds_ram.sv
rtl/pds_dp.sv
rtl/pds_ctrl.sv
rtl/polyline_distance_sampler.sv
bench/pds_checker.sv
bench/tb_polyline_distance_sampler.sv
